// File: design/box_mean_3x3_rgb_filter_defines.svh
// assertion macros for the 3x3 box mean filter
`ifndef BOX_MEAN_3X3_RGB_FILTER_DEFINES_SVH
`define BOX_MEAN_3X3_RGB_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define BMF_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("bmf assertion failed");
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("bmf assertion failed");
`else
`define BMF_ASSERT_NOW(lbl, clk, rst_n, a, b)
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: design/bmf_pkg.sv
// shared constants, types and tables of the 3x3 box mean filter
`timescale 1ns / 1ps
package bmf_pkg;
	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int DimW      = 11;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int InRowW    = $clog2(MaxHeight + 2);
	localparam int PixW      = 24;
	localparam int SumW      = 12;
	localparam int RecW      = 17;
	localparam int RecShift  = 16;
	localparam int CntW      = 4;
	localparam int CfgIdxW   = 2;

	localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;

	localparam logic [DimW-1:0] WidthReset  = 11'd640;
	localparam logic [DimW-1:0] HeightReset = 11'd480;

	localparam logic OpPixel = 1'b0;
	localparam logic OpFlush = 1'b1;

	typedef enum logic [2:0] {
		StIdle,
		StRead,
		StSum,
		StMul,
		StFix,
		StOut
	} state_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic sum;
		logic mul;
		logic fix;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic taking;
		logic emit;
		logic out_free;
	} status_t;

	function automatic logic [RecW-1:0] recip(input logic [CntW-1:0] cnt);
		logic [RecW-1:0] r;
		begin
			unique case (cnt)
				4'd1:    r = 17'd65536;
				4'd2:    r = 17'd32768;
				4'd3:    r = 17'd21845;
				4'd4:    r = 17'd16384;
				4'd5:    r = 17'd13107;
				4'd6:    r = 17'd10922;
				4'd7:    r = 17'd9362;
				4'd8:    r = 17'd8192;
				4'd9:    r = 17'd7281;
				default: r = 17'd65536;
			endcase
			return r;
		end
	endfunction
endpackage

// File: design/bmf_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module bmf_ram #(
	parameter int Width = 24,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/bmf_ctrl.sv
// controller state machine of the 3x3 box mean filter
`timescale 1ns / 1ps
module bmf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               op,
	input  bmf_pkg::status_t   status,
	output logic               in_stall,
	output bmf_pkg::cmd_t      cmd
);
	bmf_pkg::state_t state_q, state_d;
	logic take;

	assign take = in_valid && (state_q == bmf_pkg::StIdle)
		&& !(status.taking && (op == bmf_pkg::OpFlush));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmf_pkg::StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmf_pkg::StIdle: if (take) state_d = bmf_pkg::StRead;
			bmf_pkg::StRead: state_d = status.emit ? bmf_pkg::StSum : bmf_pkg::StIdle;
			bmf_pkg::StSum:  state_d = bmf_pkg::StMul;
			bmf_pkg::StMul:  state_d = bmf_pkg::StFix;
			bmf_pkg::StFix:  state_d = bmf_pkg::StOut;
			bmf_pkg::StOut:  if (status.out_free) state_d = bmf_pkg::StIdle;
			default:         state_d = bmf_pkg::StIdle;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			bmf_pkg::StIdle: begin
				in_stall    = 1'b0;
				cmd.capture = take;
			end
			bmf_pkg::StRead: cmd.step = 1'b1;
			bmf_pkg::StSum:  cmd.sum = 1'b1;
			bmf_pkg::StMul:  cmd.mul = 1'b1;
			bmf_pkg::StFix:  cmd.fix = 1'b1;
			bmf_pkg::StOut:  cmd.load_out = status.out_free;
			default:         cmd = '0;
		endcase
	end
endmodule

// File: design/bmf_dp.sv
// datapath: size registers, positions, line stores, window and mean arithmetic
`timescale 1ns / 1ps
module bmf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bmf_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [bmf_pkg::DimW-1:0]          cfg_data,
	input  logic [7:0]                        chan0_in,
	input  logic [7:0]                        chan1_in,
	input  logic [7:0]                        chan2_in,
	input  bmf_pkg::cmd_t                     cmd,
	output bmf_pkg::status_t                  status,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [7:0]                        chan0_out,
	output logic [7:0]                        chan1_out,
	output logic [7:0]                        chan2_out,
	output logic                              frame_end
);
	localparam int DimW = bmf_pkg::DimW;
	localparam int SumW = bmf_pkg::SumW;
	localparam int PrdW = bmf_pkg::SumW + bmf_pkg::RecW;

	logic [DimW-1:0]               width_q, height_q, w_eff, h_eff;
	logic [bmf_pkg::ColW-1:0]      in_col_q, out_x_q;
	logic [bmf_pkg::InRowW-1:0]    in_row_q;
	logic [bmf_pkg::RowW-1:0]      out_y_q;
	logic [bmf_pkg::PixW-1:0]      pix_q;
	logic                          emit_q;
	logic [bmf_pkg::PixW-1:0]      win_q [9];
	logic [bmf_pkg::PixW-1:0]      upper_rd, middle_rd;
	logic [SumW-1:0]               sum_q [3];
	logic [bmf_pkg::CntW-1:0]      cnt_q;
	logic [PrdW-1:0]               prod_q [3];
	logic [7:0]                    res_q [3];
	logic                          out_valid_q;
	logic                          cfg_hit, col_wrap, last_x, last_y;
	logic [8:0]                    mask;
	logic                          top_ok, bot_ok, lft_ok, rgt_ok;

	assign w_eff = (width_q == '0) ? DimW'(1) :
		(width_q > DimW'(bmf_pkg::MaxWidth)) ? DimW'(bmf_pkg::MaxWidth) : width_q;
	assign h_eff = (height_q == '0) ? DimW'(1) :
		(height_q > DimW'(bmf_pkg::MaxHeight)) ? DimW'(bmf_pkg::MaxHeight) : height_q;

	assign cfg_hit  = cfg_we && (cfg_index == bmf_pkg::CfgWidth
		|| cfg_index == bmf_pkg::CfgHeight);
	assign col_wrap = (DimW'(in_col_q) + DimW'(1)) == w_eff;
	assign last_x   = (DimW'(out_x_q) + DimW'(1)) == w_eff;
	assign last_y   = (DimW'(out_y_q) + DimW'(1)) == h_eff;

	assign status.taking   = DimW'(in_row_q) < h_eff;
	assign status.emit     = emit_q;
	assign status.out_free = !out_valid_q || !out_stall;

	// neighbour rows and columns that lie inside the image
	assign top_ok = out_y_q != '0;
	assign bot_ok = !last_y;
	assign lft_ok = out_x_q != '0;
	assign rgt_ok = !last_x;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mask[r*3+c] = ((r != 0) || top_ok) && ((r != 2) || bot_ok)
					&& ((c != 0) || lft_ok) && ((c != 2) || rgt_ok);
			end
		end
	end

	bmf_ram #(.Width(bmf_pkg::PixW), .Depth(bmf_pkg::MaxWidth)) u_upper (
		.clk   (clk),
		.we    (cmd.step),
		.waddr (in_col_q),
		.wdata (middle_rd),
		.raddr (in_col_q),
		.rdata (upper_rd)
	);

	bmf_ram #(.Width(bmf_pkg::PixW), .Depth(bmf_pkg::MaxWidth)) u_middle (
		.clk   (clk),
		.we    (cmd.step),
		.waddr (in_col_q),
		.wdata (pix_q),
		.raddr (in_col_q),
		.rdata (middle_rd)
	);

	// configuration and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmf_pkg::WidthReset;
			height_q <= bmf_pkg::HeightReset;
			in_col_q <= '0;
			in_row_q <= '0;
			out_x_q  <= '0;
			out_y_q  <= '0;
			emit_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == bmf_pkg::CfgWidth) begin
				width_q <= cfg_data;
			end
			if (cfg_we && cfg_index == bmf_pkg::CfgHeight) begin
				height_q <= cfg_data;
			end
			if (cmd.capture) begin
				emit_q <= (in_row_q >= bmf_pkg::InRowW'(2))
					|| (in_row_q == bmf_pkg::InRowW'(1) && in_col_q != '0);
			end
			if (cfg_hit) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_x_q  <= '0;
				out_y_q  <= '0;
			end else if (cmd.step) begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + bmf_pkg::InRowW'(1);
				end else begin
					in_col_q <= in_col_q + bmf_pkg::ColW'(1);
				end
			end else if (cmd.load_out) begin
				if (last_x && last_y) begin
					in_col_q <= '0;
					in_row_q <= '0;
					out_x_q  <= '0;
					out_y_q  <= '0;
				end else if (last_x) begin
					out_x_q <= '0;
					out_y_q <= out_y_q + bmf_pkg::RowW'(1);
				end else begin
					out_x_q <= out_x_q + bmf_pkg::ColW'(1);
				end
			end
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.step) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= upper_rd;
			win_q[5] <= middle_rd;
			win_q[8] <= pix_q;
		end
	end

	// pixel capture and mean arithmetic
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= status.taking ? {chan2_in, chan1_in, chan0_in} : '0;
		end
		if (cmd.sum) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [SumW-1:0] acc;
				acc = '0;
				for (int i = 0; i < 9; i++) begin
					acc = acc + (mask[i] ? SumW'(win_q[i][ch*8 +: 8]) : SumW'(0));
				end
				sum_q[ch] <= acc;
			end
			cnt_q <= bmf_pkg::CntW'($countones(mask));
		end
		if (cmd.mul) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_q[ch] <= PrdW'(sum_q[ch]) * PrdW'(bmf_pkg::recip(cnt_q));
			end
		end
		if (cmd.fix) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [SumW-1:0] q0, rem;
				q0  = prod_q[ch][bmf_pkg::RecShift +: SumW];
				rem = sum_q[ch] - SumW'(q0 * SumW'(cnt_q));
				res_q[ch] <= (rem >= SumW'(cnt_q)) ? q0[7:0] + 8'd1 : q0[7:0];
			end
		end
		if (cmd.load_out) begin
			chan0_out <= res_q[0];
			chan1_out <= res_q[1];
			chan2_out <= res_q[2];
			frame_end <= last_x && last_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: design/box_mean_3x3_rgb_filter.sv
// top level of the 3x3 box mean filter for 24-bit rgb pixels
//
//   channel  signals                                    request
//   in       in_valid in_stall op chan0_in..chan2_in    pixel or flush
//   out      out_valid out_stall chan0_out..chan2_out   mean pixel, frame_end
//            frame_end
//   cfg      cfg_we cfg_index cfg_data                  size register write
//
// a request giving no result passes the capture and registered line store read states;
// one giving a result then also passes the sum, multiply, correct and output states
// a flush while pixels are still expected is accepted without leaving idle and dropped
// asynchronous reset; line stores need no clearing pass
// a waiting result holds in the output register while the next request is taken
`timescale 1ns / 1ps
`include "box_mean_3x3_rgb_filter_defines.svh"
module box_mean_3x3_rgb_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bmf_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [bmf_pkg::DimW-1:0]        cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [7:0]                      chan0_in,
	input  logic [7:0]                      chan1_in,
	input  logic [7:0]                      chan2_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      chan0_out,
	output logic [7:0]                      chan1_out,
	output logic [7:0]                      chan2_out,
	output logic                            frame_end
);
	bmf_pkg::cmd_t    cmd;
	bmf_pkg::status_t status;

	bmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	bmf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chan0_in  (chan0_in),
		.chan1_in  (chan1_in),
		.chan2_in  (chan2_in),
		.cmd       (cmd),
		.status    (status),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.chan0_out (chan0_out),
		.chan1_out (chan1_out),
		.chan2_out (chan2_out),
		.frame_end (frame_end)
	);

	`BMF_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd))
	`BMF_ASSERT_NEXT(a_flush_dropped, clk, arst_n,
		in_valid && !in_stall && status.taking && op == bmf_pkg::OpFlush, !in_stall)
	`BMF_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load_out, out_valid)
	`BMF_ASSERT_NOW(a_load_needs_room, clk, arst_n, cmd.load_out,
		!out_valid || !out_stall)
endmodule

// File: tb/tb_box_mean_3x3_rgb_filter.sv
// self-checking testbench of the 3x3 box mean filter with a built-in mean predictor
`timescale 1ns / 1ps
module tb_box_mean_3x3_rgb_filter;
	typedef struct {
		logic       op;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} pixel_req_t;

	typedef struct {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       fe;
	} mean_pix_t;

	localparam int IdleLimit = 2000;
	localparam int SettleCycles = 10;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [bmf_pkg::CfgIdxW-1:0] cfg_index = bmf_pkg::CfgWidth;
	logic [bmf_pkg::DimW-1:0]    cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        op = bmf_pkg::OpPixel;
	logic [7:0]                  chan0_in = '0;
	logic [7:0]                  chan1_in = '0;
	logic [7:0]                  chan2_in = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [7:0]                  chan0_out;
	logic [7:0]                  chan1_out;
	logic [7:0]                  chan2_out;
	logic                        frame_end;

	box_mean_3x3_rgb_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .op(op),
		.chan0_in(chan0_in), .chan1_in(chan1_in), .chan2_in(chan2_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.chan0_out(chan0_out), .chan1_out(chan1_out), .chan2_out(chan2_out),
		.frame_end(frame_end)
	);

	always #1 clk = ~clk;

	pixel_req_t pending[$];
	mean_pix_t  expected_means[$];
	int         errors = 0;
	int         idle_cycles = 0;
	int         hold_cycles = 0;
	int         send_gap = 0;
	int         recv_gap = 0;
	bit         calm = 1'b0;
	bit         req_taken = 1'b0;

	// predictor state
	logic [bmf_pkg::DimW-1:0] width_reg = bmf_pkg::WidthReset;
	logic [bmf_pkg::DimW-1:0] height_reg = bmf_pkg::HeightReset;
	logic [23:0]              upper_row[bmf_pkg::MaxWidth];
	logic [23:0]              middle_row[bmf_pkg::MaxWidth];
	logic [23:0]              win[9];
	int                       in_pos = 0;
	int                       out_pos = 0;

	function automatic int clamp_dim(input logic [bmf_pkg::DimW-1:0] v, input int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic int frame_w();
		return clamp_dim(width_reg, bmf_pkg::MaxWidth);
	endfunction

	function automatic int frame_h();
		return clamp_dim(height_reg, bmf_pkg::MaxHeight);
	endfunction

	task automatic predict_mean(input pixel_req_t r, output bit has, output mean_pix_t m);
		int w, h, total, col, x, y, cnt, s0, s1, s2;
		logic [23:0] pix, top, mid, p;
		w = frame_w();
		h = frame_h();
		total = w * h;
		has = 1'b0;
		m = '{8'd0, 8'd0, 8'd0, 1'b0};
		if (in_pos < total && r.op == bmf_pkg::OpFlush)
			return;
		pix = (in_pos < total) ? {r.c2, r.c1, r.c0} : 24'd0;
		col = in_pos % w;
		top = upper_row[col];
		mid = middle_row[col];
		upper_row[col] = mid;
		middle_row[col] = pix;
		for (int i = 0; i < 3; i++) begin
			win[i*3] = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = pix;
		in_pos++;
		if (in_pos < w + 2)
			return;
		x = out_pos % w;
		y = out_pos / w;
		cnt = 0;
		s0 = 0;
		s1 = 0;
		s2 = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if ((dr < 0 && y == 0) || (dr > 0 && y + 1 >= h) ||
						(dc < 0 && x == 0) || (dc > 0 && x + 1 >= w))
					continue;
				p = win[(dr+1)*3 + dc + 1];
				s0 += p[7:0];
				s1 += p[15:8];
				s2 += p[23:16];
				cnt++;
			end
		end
		m.c0 = 8'(s0 / cnt);
		m.c1 = 8'(s1 / cnt);
		m.c2 = 8'(s2 / cnt);
		has = 1'b1;
		out_pos++;
		if (out_pos >= total) begin
			m.fe = 1'b1;
			in_pos = 0;
			out_pos = 0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !req_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 2);
				in_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				in_valid <= 1'b1;
				op <= pending[0].op;
				chan0_in <= pending[0].c0;
				chan1_in <= pending[0].c1;
				chan2_in <= pending[0].c2;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			recv_gap = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// request acceptance, result check and watchdog
	always @(posedge clk) begin
		pixel_req_t r;
		mean_pix_t  m, e;
		bit         has;
		req_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				req_taken = 1'b1;
				r = '{op, chan0_in, chan1_in, chan2_in};
				void'(pending.pop_front());
				predict_mean(r, has, m);
				if (has)
					expected_means.push_back(m);
			end
			if (out_valid && !out_stall) begin
				if (expected_means.size() == 0) begin
					report_mismatch("result with none expected");
				end else begin
					e = expected_means.pop_front();
					if (chan0_out !== e.c0)
						report_mismatch($sformatf("chan0 %0h exp %0h", chan0_out, e.c0));
					if (chan1_out !== e.c1)
						report_mismatch($sformatf("chan1 %0h exp %0h", chan1_out, e.c1));
					if (chan2_out !== e.c2)
						report_mismatch($sformatf("chan2 %0h exp %0h", chan2_out, e.c2));
					if (frame_end !== e.fe)
						report_mismatch($sformatf("frame_end %0b exp %0b", frame_end, e.fe));
				end
			end
			if (req_taken || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_req(input logic o, input logic [7:0] a, b, c);
		pixel_req_t r;
		r = '{o, a, b, c};
		pending.push_back(r);
	endtask

	task automatic drain_all();
		while (pending.size() > 0 || expected_means.size() > 0 || in_valid)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bmf_pkg::CfgIdxW-1:0] idx,
			input logic [bmf_pkg::DimW-1:0] val);
		drain_all();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == bmf_pkg::CfgWidth)
			width_reg = val;
		else
			height_reg = val;
		in_pos = 0;
		out_pos = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(input logic [bmf_pkg::DimW-1:0] w, h);
		write_reg(bmf_pkg::CfgWidth, w);
		write_reg(bmf_pkg::CfgHeight, h);
	endtask

	// one frame; cut >= 0 stops after that many pixels
	task automatic send_frame(input int cut, output int sent);
		int total, w;
		w = frame_w();
		total = w * frame_h();
		sent = 0;
		for (int i = 0; i < total; i++) begin
			if (i == cut)
				return;
			if ($urandom_range(0, 11) == 0) begin
				push_req(bmf_pkg::OpFlush, pick_byte(), pick_byte(), pick_byte());
				sent++;
			end
			push_req(bmf_pkg::OpPixel, pick_byte(), pick_byte(), pick_byte());
			sent++;
		end
		for (int i = 0; i <= w; i++) begin
			push_req($urandom_range(0, 3) == 0 ? bmf_pkg::OpPixel : bmf_pkg::OpFlush,
				pick_byte(), pick_byte(), pick_byte());
			sent++;
		end
	endtask

	initial begin
		int sent, n, cut;
		for (int i = 0; i < bmf_pkg::MaxWidth; i++) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: 3x3 frame with extreme values, early flush, pixel in drain
		set_size(11'd3, 11'd3);
		push_req(bmf_pkg::OpFlush, 8'hff, 8'hff, 8'hff);
		push_req(bmf_pkg::OpPixel, 8'h00, 8'h00, 8'h00);
		push_req(bmf_pkg::OpPixel, 8'hff, 8'hff, 8'hff);
		push_req(bmf_pkg::OpPixel, 8'haa, 8'h55, 8'haa);
		push_req(bmf_pkg::OpPixel, 8'h55, 8'haa, 8'h55);
		push_req(bmf_pkg::OpFlush, 8'h00, 8'h00, 8'h00);
		push_req(bmf_pkg::OpPixel, 8'hff, 8'h00, 8'hff);
		push_req(bmf_pkg::OpPixel, 8'h01, 8'h80, 8'h7f);
		push_req(bmf_pkg::OpPixel, 8'hfe, 8'h7f, 8'h80);
		push_req(bmf_pkg::OpPixel, 8'hff, 8'hff, 8'hff);
		push_req(bmf_pkg::OpPixel, 8'hff, 8'hff, 8'hff);
		push_req(bmf_pkg::OpFlush, 8'h00, 8'h00, 8'h00);
		push_req(bmf_pkg::OpPixel, 8'h12, 8'h34, 8'h56);
		push_req(bmf_pkg::OpFlush, 8'h00, 8'h00, 8'h00);
		push_req(bmf_pkg::OpFlush, 8'h00, 8'h00, 8'h00);
		// zero sizes act as one pixel
		set_size(11'd0, 11'd0);
		push_req(bmf_pkg::OpPixel, 8'hff, 8'h00, 8'h80);
		push_req(bmf_pkg::OpFlush, 8'h00, 8'h00, 8'h00);
		push_req(bmf_pkg::OpPixel, 8'h00, 8'hff, 8'h7f);

		// random frames
		n = 0;
		while (n < 480) begin
			if ($urandom_range(0, 2) == 0 || n == 0)
				set_size(bmf_pkg::DimW'($urandom_range(0, 9)),
					bmf_pkg::DimW'($urandom_range(0, 6)));
			if ($urandom_range(0, 4) == 0)
				drain_all();
			cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 5)) : -1;
			send_frame(cut, sent);
			n += sent;
			if (cut >= 0)
				write_reg(bmf_pkg::CfgHeight, height_reg);
		end

		// long receiver hold while the sender keeps going
		set_size(11'd8, 11'd5);
		drain_all();
		hold_cycles = 300;
		send_frame(-1, sent);

		// largest and out-of-range sizes
		set_size(11'd2047, 11'd1);
		send_frame(40, sent);
		set_size(11'd1, 11'd2047);
		send_frame(40, sent);
		set_size(11'd1024, 11'd1024);
		set_size(11'd4, 11'd1024);
		send_frame(12, sent);
		write_reg(bmf_pkg::CfgWidth, 11'd5);
		set_size(11'd5, 11'd4);

		// last part runs without idling
		drain_all();
		calm = 1'b1;
		for (int i = 0; i < 3; i++)
			send_frame(-1, sent);
		drain_all();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
